// ===== rtl/dnc_pkg.sv =====
package dnc_pkg;

  localparam int unsigned BufferBytes = 4096;
  localparam int unsigned SuffixSlots = 128;
  localparam int unsigned SlotBytes = 128;
  localparam int unsigned NameBytes = 255;
  localparam int unsigned PtrLimit = 16384;
  localparam int unsigned MaxSuffix = 128;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdRaw   = 2'd1,
    CmdName  = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        last;
    logic [11:0] read_address;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [12:0] message_length;
    logic [7:0]  read_data;
  } out_word_t;

  typedef enum logic [4:0] {
    StIdle,
    StRead,
    StScanRd,
    StScanWait,
    StScan,
    StSuffix,
    StSlot,
    StCmpLen,
    StCmpWait,
    StCmp,
    StPtrHi,
    StPtrLo,
    StStore,
    StStoreWr,
    StLabRd,
    StLabWait,
    StLabWr,
    StRoot,
    StDone
  } state_e;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

endpackage

// ===== rtl/dns_response_name_compressor_top.sv =====
// dns response builder with name compression
// input channel: in_word_i is taken at a rising edge with start high and
// busy low. the command codes are start message, append raw byte, load
// one name byte and read one byte of the message
// output channel: each word appears on out_word_o for exactly one cycle
// with done_o high; the receiver cannot stall, so no word is ever held
// start, raw append and name bytes without the last mark go straight to the
// done state; a read passes through a registered buffer read first
// a name's last byte runs a sequencer over one shared byte compare unit:
// it scans the labels, then for every suffix compares its length and bytes
// against each stored slot; a match appends a two-byte pointer and ends the
// name, else the suffix is stored if it fits and its first label is copied
// into the message; the root byte ends a name that found no match
// reset clears the fill count, the used slot count and the pending name
// count; the message, suffix and name memories hold whatever they held and
// are only read below their fill counts
module dns_response_name_compressor_top #(
  parameter int unsigned BUFFER_BYTES = dnc_pkg::BufferBytes,
  parameter int unsigned SUFFIX_SLOTS = dnc_pkg::SuffixSlots,
  parameter int unsigned SLOT_BYTES   = dnc_pkg::SlotBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  dnc_pkg::in_word_t  in_word_i,
  output logic               done_o,
  output dnc_pkg::out_word_t out_word_o
);
  import dnc_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned SW = $clog2(SUFFIX_SLOTS);
  localparam int unsigned BW = $clog2(SLOT_BYTES);
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned UW = $clog2(SUFFIX_SLOTS + 1);

  // memories
  logic [7:0]  msg_mem [BUFFER_BYTES];
  logic [7:0]  sfx_mem [2**(SW+BW)];
  logic [13:0] off_mem [SUFFIX_SLOTS];
  logic [7:0]  len_mem [SUFFIX_SLOTS];
  logic [7:0]  name_mem [256];

  state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [UW-1:0] used_q, used_d;
  logic [7:0]    pfill_q, pfill_d;
  logic [7:0]    pos_q, pos_d;      // scan / suffix start
  logic [7:0]    endp_q, endp_d;
  logic [UW-1:0] slot_q, slot_d;
  logic [7:0]    q_q, q_d;          // byte index in compare or copy
  logic [7:0]    lab_q, lab_d;      // bytes left in current label (compare)
  logic [8:0]    dlen_q, dlen_d;
  logic          status_q, status_d;
  logic [7:0]    rdat_q, rdat_d;
  logic [11:0]   raddr_q, raddr_d;
  logic [13:0]   off_q, off_d;

  // memory ports
  logic          mw_en;  logic [AW-1:0] mw_a; logic [7:0] mw_d;
  logic [AW-1:0] mr_a;   logic [7:0] mr_q;
  logic          nw_en;  logic [7:0] nw_a; logic [7:0] nw_d;
  logic [7:0]    nr_a;   logic [7:0] nr_q;
  logic          sw_en;  logic [SW+BW-1:0] sw_a; logic [7:0] sw_d;
  logic [SW+BW-1:0] sr_a; logic [7:0] sr_q;
  logic          tw_en;  logic [13:0] tw_off; logic [7:0] tw_len;
  logic [SW-1:0] tr_a;   logic [13:0] tr_off; logic [7:0] tr_len;

  always_ff @(posedge clk_i) begin
    if (mw_en) msg_mem[mw_a] <= mw_d;
    mr_q <= msg_mem[mr_a];
    if (nw_en) name_mem[nw_a] <= nw_d;
    nr_q <= name_mem[nr_a];
    if (sw_en) sfx_mem[sw_a] <= sw_d;
    sr_q <= sfx_mem[sr_a];
    if (tw_en) begin
      off_mem[used_q[SW-1:0]] <= tw_off;
      len_mem[used_q[SW-1:0]] <= tw_len;
    end
    tr_off <= off_mem[tr_a];
    tr_len <= len_mem[tr_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      used_q   <= '0;
      pfill_q  <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      used_q   <= used_d;
      pfill_q  <= pfill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; endp_q <= endp_d; slot_q <= slot_d; q_q <= q_d;
    lab_q <= lab_d; dlen_q <= dlen_d; status_q <= status_d;
    rdat_q <= rdat_d; raddr_q <= raddr_d; off_q <= off_d;
  end

  logic [FW-1:0] room;
  logic [8:0]    rem9;
  logic [8:0]    nxt9;
  assign room = FW'(BUFFER_BYTES) - fill_q;
  assign rem9 = {1'b0, pfill_q} - {1'b0, pos_q} - 9'd1;
  assign nxt9 = {1'b0, pos_q} + {1'b0, nr_q} + 9'd1;

  always_comb begin
    state_d = state_q; fill_d = fill_q; used_d = used_q; pfill_d = pfill_q;
    pos_d = pos_q; endp_d = endp_q; slot_d = slot_q; q_d = q_q; lab_d = lab_q;
    dlen_d = dlen_q; status_d = status_q; rdat_d = rdat_q; raddr_d = raddr_q;
    off_d = off_q;
    mw_en = 1'b0; mw_a = fill_q[AW-1:0]; mw_d = nr_q;
    mr_a = raddr_q[AW-1:0];
    nw_en = 1'b0; nw_a = pfill_q; nw_d = in_word_i.data_byte;
    nr_a = pos_q;
    sw_en = 1'b0; sw_a = {used_q[SW-1:0], q_q[BW-1:0]}; sw_d = nr_q;
    sr_a = {slot_q[SW-1:0], q_q[BW-1:0]};
    tw_en = 1'b0; tw_off = 14'(fill_q); tw_len = dlen_q[7:0];
    tr_a = slot_q[SW-1:0];
    case (state_q)
      StIdle: begin
        if (start) begin
          status_d = 1'b0; rdat_d = '0; raddr_d = in_word_i.read_address;
          state_d = StDone;
          case (in_word_i.command)
            CmdStart: begin
              fill_d = '0; used_d = '0; pfill_d = '0;
            end
            CmdRaw: begin
              if (room == '0) status_d = 1'b1;
              else begin
                mw_en = 1'b1; mw_d = in_word_i.data_byte; fill_d = fill_q + FW'(1);
              end
            end
            CmdName: begin
              if (pfill_q < 8'(NameBytes)) begin
                nw_en = 1'b1; pfill_d = pfill_q + 8'd1;
              end
              if (in_word_i.last) begin
                pos_d = '0; state_d = StScanRd;
              end
            end
            default: begin
              if ({1'b0, in_word_i.read_address} < 13'(fill_q)) state_d = StRead;
            end
          endcase
        end
      end
      StRead: state_d = StScanWait;  // buffer read of raddr_q issued here
      StScanRd: begin
        if (pos_q >= pfill_q) begin
          endp_d = pos_q; state_d = StSuffix; nw_en = 1'b1; nw_a = pos_q;
          nw_d = '0; pos_d = '0;
        end else state_d = StScan;
      end
      StScanWait: begin
        // read data of the message buffer is ready here
        rdat_d = mr_q; state_d = StDone;
      end
      StScan: begin
        if (nr_q == 8'd0) begin
          endp_d = pos_q; nw_en = 1'b1; nw_a = pos_q; nw_d = '0;
          pos_d = '0; state_d = StSuffix;
        end else if ({1'b0, nr_q} > rem9) begin
          nw_en = 1'b1; nw_a = pos_q; nw_d = rem9[7:0];
          if (rem9 == 9'd0) begin
            endp_d = pos_q; nw_d = '0; pos_d = '0; state_d = StSuffix;
          end else begin
            endp_d = pfill_q; pos_d = '0; state_d = StSuffix;
            // clamped label reaches exactly the end of the loaded bytes
          end
        end else begin
          pos_d = nxt9[7:0];
          state_d = StScanRd;
        end
      end
      StSuffix: begin
        if (endp_q == pfill_q && pos_q == '0 && endp_q != '0) begin
          // root mark sits one past the loaded bytes
          nw_en = 1'b1; nw_a = endp_q; nw_d = '0;
        end
        if (pos_q >= endp_q) state_d = StRoot;
        else begin
          dlen_d = {1'b0, endp_q} - {1'b0, pos_q} + 9'd1; slot_d = '0; state_d = StSlot;
        end
      end
      StSlot: begin
        if (slot_q >= used_q) state_d = StStore;
        else begin
          q_d = '0; state_d = StCmpLen;
        end
      end
      StCmpLen: begin
        nr_a = pos_q + q_q; state_d = StCmpWait;
      end
      StCmpWait: begin
        if ({1'b0, tr_len} != dlen_q) begin
          slot_d = slot_q + UW'(1); state_d = StSlot;
        end else begin
          lab_d = '0; nr_a = pos_q; state_d = StCmp;
        end
      end
      StCmp: begin
        // nr_q: name byte pos+q, sr_q: slot byte q; lab_q = chars left
        nr_a = pos_q + q_q + 8'd1;
        sr_a = {slot_q[SW-1:0], BW'(q_q + 8'd1)};
        if ({1'b0, q_q} >= dlen_q) begin
          off_d = tr_off; state_d = StPtrHi;
        end else if (lab_q == '0) begin
          if (sr_q != nr_q) begin
            slot_d = slot_q + UW'(1); state_d = StSlot;
          end else if (nr_q == '0) begin
            off_d = tr_off; state_d = StPtrHi;
          end else begin
            lab_d = nr_q; q_d = q_q + 8'd1;
          end
        end else begin
          if (fold(sr_q) != fold(nr_q)) begin
            slot_d = slot_q + UW'(1); state_d = StSlot;
          end else begin
            lab_d = lab_q - 8'd1; q_d = q_q + 8'd1;
          end
        end
      end
      StPtrHi: begin
        if (room < FW'(2)) begin
          status_d = 1'b1; state_d = StDone;
        end else begin
          mw_en = 1'b1; mw_d = {2'b11, off_q[13:8]};
          fill_d = fill_q + FW'(1); state_d = StPtrLo;
        end
      end
      StPtrLo: begin
        mw_en = 1'b1; mw_d = off_q[7:0]; fill_d = fill_q + FW'(1); state_d = StDone;
      end
      StStore: begin
        q_d = '0;
        if (dlen_q <= 9'(MaxSuffix) && dlen_q <= 9'(SLOT_BYTES) &&
            used_q < UW'(SUFFIX_SLOTS) && 15'(fill_q) < 15'(PtrLimit)) begin
          nr_a = pos_q; state_d = StStoreWr;
        end else state_d = StLabRd;
      end
      StStoreWr: begin
        // nr_q holds byte pos+q
        nr_a = pos_q + q_q + 8'd1;
        sw_en = 1'b1;
        if ({1'b0, q_q} + 9'd1 >= dlen_q) begin
          tw_en = 1'b1; used_d = used_q + UW'(1); state_d = StLabRd;
        end else q_d = q_q + 8'd1;
      end
      StLabRd: begin
        q_d = '0; nr_a = pos_q; state_d = StLabWait;
      end
      StLabWait: begin
        lab_d = nr_q;
        if ((FW'(nr_q) + FW'(1)) > room) begin
          status_d = 1'b1; state_d = StDone;
        end else begin
          nr_a = pos_q; state_d = StLabWr;
        end
      end
      StLabWr: begin
        nr_a = pos_q + q_q + 8'd1;
        mw_en = 1'b1; fill_d = fill_q + FW'(1);
        if (q_q >= lab_q) begin
          pos_d = pos_q + lab_q + 8'd1; state_d = StSuffix;
        end else q_d = q_q + 8'd1;
      end
      StRoot: begin
        if (room == '0) status_d = 1'b1;
        else begin
          mw_en = 1'b1; mw_d = '0; fill_d = fill_q + FW'(1);
        end
        state_d = StDone;
      end
      StDone: begin
        if (endp_q != 8'hff) pfill_d = pfill_q;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // a name run always ends with the pending name emptied
    if (state_d == StDone && state_q != StIdle && state_q != StScanWait &&
        state_q != StRead)
      pfill_d = '0;
  end

  assign busy = (state_q != StIdle);
  assign done_o = (state_q == StDone);
  assign out_word_o.status = status_q;
  assign out_word_o.message_length = 13'(fill_q);
  assign out_word_o.read_data = rdat_q;

  // assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(BUFFER_BYTES)) else $error("fill beyond buffer");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(SUFFIX_SLOTS)) else $error("slot count beyond table");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held more than one cycle");
  a_ptr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPtrLo |-> $past(state_q) == StPtrHi) else $error("pointer split");

endmodule
